// File: hdl/fit_policy_hole_allocator_defines.svh
// Assertion macros for the fit-policy hole allocator.
`ifndef FIT_POLICY_HOLE_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_HOLE_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPHA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fit policy hole allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fit policy hole allocator: next-cycle check failed");

`endif

// File: hdl/fpha_pkg.sv
// Shared types and constants for the fit-policy hole allocator.
package fpha_pkg;

    localparam int MAX_HOLES_DEF    = 16;
    localparam int SIZE_BITS_DEF    = 16;
    localparam int FIELD_BITS       = 16;
    localparam int INDEX_FIELD_BITS = 4;
    localparam int COUNT_FIELD_BITS = 5;
    localparam int FUNC_BITS        = 2;
    localparam logic [COUNT_FIELD_BITS-1:0] HOLE_COUNT_RESET = 5'd16;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_FIRST = 2'd1,
        FUNC_BEST  = 2'd2,
        FUNC_WORST = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic                        done;
        logic                        granted;
        logic [INDEX_FIELD_BITS-1:0] chosen_hole;
        logic [FIELD_BITS-1:0]       size_before;
        logic [FIELD_BITS-1:0]       size_after;
    } result_t;

endpackage

// File: hdl/fit_policy_hole_allocator.sv
// Top level of the fit-policy hole allocator: hole table, request engine, hole count register.
// A load request passes through the load state; its result strobe is registered.
// An allocation scans N holes, N being hole_count saturated to MAX_HOLES; first fit
// stops at the first hole that fits, and N = 0 skips the scan and fails.
// The scan is paced by the single table read port, one hole per cycle.
// Reset sets hole_count to 16; table contents are undefined until each hole is loaded.
module fit_policy_hole_allocator #(
    parameter int MAX_HOLES = fpha_pkg::MAX_HOLES_DEF,
    parameter int SIZE_BITS = fpha_pkg::SIZE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [fpha_pkg::FUNC_BITS-1:0]        func,
    input  logic [fpha_pkg::INDEX_FIELD_BITS-1:0] hole_index,
    input  logic [fpha_pkg::FIELD_BITS-1:0]       hole_size,
    input  logic [fpha_pkg::FIELD_BITS-1:0]       request_size,
    input  logic                                  cfg_we,
    input  logic [fpha_pkg::COUNT_FIELD_BITS-1:0] cfg_wdata,
    output logic                                  done,
    output logic                                  granted,
    output logic [fpha_pkg::INDEX_FIELD_BITS-1:0] chosen_hole,
    output logic [fpha_pkg::FIELD_BITS-1:0]       size_before,
    output logic [fpha_pkg::FIELD_BITS-1:0]       size_after
);
    import fpha_pkg::*;
    `include "fit_policy_hole_allocator_defines.svh"

    localparam int IDX_BITS = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CNT_BITS = $clog2(MAX_HOLES + 1);

    // The hole count register is written whenever the write enable is high; the
    // user only writes it while no request is in flight.
    logic [COUNT_FIELD_BITS-1:0] hole_count_reg, hole_count_next;

    // Number of holes that an allocation request searches, saturated to the table depth.
    logic [CNT_BITS-1:0] limit;

    logic                 rd_en;
    logic [IDX_BITS-1:0]  rd_addr;
    logic [SIZE_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    result_t              result;

    assign hole_count_next = cfg_we ? cfg_wdata : hole_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_count_reg <= HOLE_COUNT_RESET;
        end
        else
        begin
            hole_count_reg <= hole_count_next;
        end
    end

    always_comb
    begin
        if (int'(hole_count_reg) > MAX_HOLES)
        begin
            limit = CNT_BITS'(MAX_HOLES);
        end
        else
        begin
            limit = CNT_BITS'(hole_count_reg);
        end
    end

    // The engine reads the table one hole per cycle and evaluates each size the
    // cycle after its read. The chosen hole's size is held in the engine, so the
    // write-back needs no second read. Reads of one request never overlap a write
    // of the same request, because the write happens only after the scan ends.
    fpha_engine #(
        .MAX_HOLES (MAX_HOLES),
        .SIZE_BITS (SIZE_BITS),
        .IDX_BITS  (IDX_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .hole_index   (hole_index),
        .hole_size    (hole_size),
        .request_size (request_size),
        .limit        (limit),
        .busy         (busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .result       (result)
    );

    fpha_mem #(
        .DEPTH     (MAX_HOLES),
        .WIDTH     (SIZE_BITS),
        .ADDR_BITS (IDX_BITS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Each result is shown for exactly one cycle, in the cycle the engine has
    // already returned to idle, so the next request may be accepted alongside it.
    assign done        = result.done;
    assign granted     = result.granted;
    assign chosen_hole = result.chosen_hole;
    assign size_before = result.size_before;
    assign size_after  = result.size_after;

    `FPHA_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
    `FPHA_ASSERT_SAME(a_done_when_idle, done, !busy)
    `FPHA_ASSERT_SAME(a_refused_sizes_zero, done && !granted, (size_before == '0) && (size_after == '0))

endmodule

// File: hdl/fpha_mem.sv
// Hole size table: synchronous single-port-write, single-port-read memory.
module fpha_mem #(
    parameter int DEPTH = fpha_pkg::MAX_HOLES_DEF,
    parameter int WIDTH = fpha_pkg::SIZE_BITS_DEF,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data
);
    import fpha_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/fpha_engine.sv
// Request sequencer: load, table scan with fit selection, and write-back.
module fpha_engine #(
    parameter int MAX_HOLES = fpha_pkg::MAX_HOLES_DEF,
    parameter int SIZE_BITS = fpha_pkg::SIZE_BITS_DEF,
    parameter int IDX_BITS  = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1,
    parameter int CNT_BITS  = $clog2(MAX_HOLES + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [fpha_pkg::FUNC_BITS-1:0]         func,
    input  logic [fpha_pkg::INDEX_FIELD_BITS-1:0]  hole_index,
    input  logic [fpha_pkg::FIELD_BITS-1:0]        hole_size,
    input  logic [fpha_pkg::FIELD_BITS-1:0]        request_size,
    input  logic [CNT_BITS-1:0]                    limit,
    output logic                                   busy,
    output logic                                   rd_en,
    output logic [IDX_BITS-1:0]                    rd_addr,
    input  logic [SIZE_BITS-1:0]                   rd_data,
    output logic                                   wr_en,
    output logic [IDX_BITS-1:0]                    wr_addr,
    output logic [SIZE_BITS-1:0]                   wr_data,
    output fpha_pkg::result_t                      result
);
    import fpha_pkg::*;

    state_t                      state_reg, state_next;
    func_t                       func_reg, func_next;
    logic [INDEX_FIELD_BITS-1:0] idx_reg, idx_next;
    logic [SIZE_BITS-1:0]        hsize_reg, hsize_next;
    logic [SIZE_BITS-1:0]        req_reg, req_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                        rvalid_reg, rvalid_next;
    logic [IDX_BITS-1:0]         tag_reg, tag_next;
    logic                        found_reg, found_next;
    logic [IDX_BITS-1:0]         pick_reg, pick_next;
    logic [SIZE_BITS-1:0]        best_reg, best_next;
    logic                        done_reg, done_next;
    logic                        granted_reg, granted_next;
    logic [INDEX_FIELD_BITS-1:0] chosen_reg, chosen_next;
    logic [FIELD_BITS-1:0]       before_reg, before_next;
    logic [FIELD_BITS-1:0]       after_reg, after_next;

    logic accept;
    logic fits;
    logic last_tag;
    logic scan_end;
    logic take;
    logic issue;
    logic idx_ok;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign fits     = (req_reg <= rd_data);
    assign last_tag = (CNT_BITS'(tag_reg) == (limit - CNT_BITS'(1)));
    assign scan_end = rvalid_reg && (last_tag || ((func_reg == FUNC_FIRST) && fits));
    assign idx_ok   = (int'(idx_reg) < MAX_HOLES);
    assign take     = rvalid_reg && fits &&
                      (!found_reg ||
                       ((func_reg == FUNC_BEST) && (rd_data < best_reg)) ||
                       ((func_reg == FUNC_WORST) && (rd_data > best_reg)));
    assign issue    = (state_reg == S_SCAN) && (cnt_reg < limit) && !scan_end;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func_t'(func) == FUNC_LOAD)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (limit == '0)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result logic.
    always_comb
    begin
        func_next    = func_reg;
        idx_next     = idx_reg;
        hsize_next   = hsize_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        rvalid_next  = 1'b0;
        tag_next     = tag_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        chosen_next  = chosen_reg;
        before_next  = before_reg;
        after_next   = after_reg;
        rd_en        = 1'b0;
        rd_addr      = cnt_reg[IDX_BITS-1:0];
        wr_en        = 1'b0;
        wr_addr      = pick_reg;
        wr_data      = best_reg - req_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func_t'(func);
                    idx_next   = hole_index;
                    hsize_next = SIZE_BITS'(hole_size);
                    req_next   = SIZE_BITS'(request_size);
                    cnt_next   = '0;
                    found_next = 1'b0;
                end
            end
            S_LOAD:
            begin
                done_next   = 1'b1;
                chosen_next = idx_reg;
                if (idx_ok)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = IDX_BITS'(idx_reg);
                    wr_data      = hsize_reg;
                    granted_next = 1'b1;
                    before_next  = FIELD_BITS'(hsize_reg);
                    after_next   = FIELD_BITS'(hsize_reg);
                end
                else
                begin
                    granted_next = 1'b0;
                    before_next  = '0;
                    after_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    found_next = 1'b1;
                    pick_next  = tag_reg;
                    best_next  = rd_data;
                end
                if (issue)
                begin
                    rd_en       = 1'b1;
                    cnt_next    = cnt_reg + CNT_BITS'(1);
                    tag_next    = cnt_reg[IDX_BITS-1:0];
                    rvalid_next = 1'b1;
                end
            end
            S_WRITE:
            begin
                done_next = 1'b1;
                if (found_reg)
                begin
                    wr_en        = 1'b1;
                    granted_next = 1'b1;
                    chosen_next  = INDEX_FIELD_BITS'(pick_reg);
                    before_next  = FIELD_BITS'(best_reg);
                    after_next   = FIELD_BITS'(best_reg - req_reg);
                end
                else
                begin
                    granted_next = 1'b0;
                    chosen_next  = '0;
                    before_next  = '0;
                    after_next   = '0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rvalid_reg <= 1'b0;
            found_reg  <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
            found_reg  <= found_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        idx_reg     <= idx_next;
        hsize_reg   <= hsize_next;
        req_reg     <= req_next;
        tag_reg     <= tag_next;
        pick_reg    <= pick_next;
        best_reg    <= best_next;
        granted_reg <= granted_next;
        chosen_reg  <= chosen_next;
        before_reg  <= before_next;
        after_reg   <= after_next;
    end

    assign result = '{done:        done_reg,
                      granted:     granted_reg,
                      chosen_hole: chosen_reg,
                      size_before: before_reg,
                      size_after:  after_reg};

endmodule

// File: tb/fit_policy_hole_allocator_tb.sv
// Self-checking testbench for the fit-policy hole allocator: directed table, then random requests.
module fit_policy_hole_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpha_pkg::*;

    // The watchdog ends the run after this many cycles in which neither a request is
    // accepted nor a result arrives. It is many times the slowest request and the longest
    // pause of the sender, so it is far above the worst honest gap.
    localparam int STALL_LIMIT  = 1000;
    // Cycles allowed after the last result before the verdict.
    localparam int DRAIN_CYCLES = 24;
    // Random requests per hole count setting.
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASES       = 8;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // One request as it is driven onto the input ports.
    typedef struct packed {
        func_t                       func;
        logic [INDEX_FIELD_BITS-1:0] hole_index;
        logic [FIELD_BITS-1:0]       hole_size;
        logic [FIELD_BITS-1:0]       request_size;
    } alloc_req_t;

    // One result as it appears on the output ports.
    typedef struct packed {
        logic                        granted;
        logic [INDEX_FIELD_BITS-1:0] chosen_hole;
        logic [FIELD_BITS-1:0]       size_before;
        logic [FIELD_BITS-1:0]       size_after;
    } grant_t;

    // One row of the directed table. A row either writes the hole count or sends a
    // request; a request row may carry a typed-in result that replaces the prediction.
    typedef struct packed {
        row_kind_t                   kind;
        alloc_req_t                  req;
        logic [COUNT_FIELD_BITS-1:0] count_value;
        logic                        has_fixed;
        grant_t                      fixed;
    } row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [FUNC_BITS-1:0]        func;
    logic [INDEX_FIELD_BITS-1:0] hole_index;
    logic [FIELD_BITS-1:0]       hole_size;
    logic [FIELD_BITS-1:0]       request_size;
    logic                        cfg_we;
    logic [COUNT_FIELD_BITS-1:0] cfg_wdata;
    logic                        done;
    logic                        granted;
    logic [INDEX_FIELD_BITS-1:0] chosen_hole;
    logic [FIELD_BITS-1:0]       size_before;
    logic [FIELD_BITS-1:0]       size_after;

    // Shadow copy of the block's state, kept in step with every accepted request.
    logic [FIELD_BITS-1:0]       hole_sizes [MAX_HOLES_DEF];
    logic [COUNT_FIELD_BITS-1:0] hole_count_shadow;

    // Results still owed by the block, oldest first.
    grant_t                      expected_grants [$];
    row_t                        directed_rows [$];
    int                          mismatches;
    int                          stall_cycles;

    fit_policy_hole_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .hole_index   (hole_index),
        .hole_size    (hole_size),
        .request_size (request_size),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .granted      (granted),
        .chosen_hole  (chosen_hole),
        .size_before  (size_before),
        .size_after   (size_after)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Works out the result of one request and applies it to the shadow table.
    // A load always lands, since every 4-bit index is inside a 16-entry table.
    // An allocation scans holes 0 .. count-1, with the count saturated to the table
    // size; a zero request fits every hole, even one of size zero.
    function automatic grant_t predict_grant(alloc_req_t r);
        grant_t g;
        int     span;
        int     pick;
        bit     found;
        g     = '0;
        pick  = 0;
        found = 1'b0;
        if (r.func == FUNC_LOAD)
        begin
            if (int'(r.hole_index) < MAX_HOLES_DEF)
            begin
                hole_sizes[r.hole_index] = r.hole_size;
                g = '{1'b1, r.hole_index, r.hole_size, r.hole_size};
            end
            else
            begin
                g.chosen_hole = r.hole_index;
            end
            return g;
        end
        span = (int'(hole_count_shadow) > MAX_HOLES_DEF) ? MAX_HOLES_DEF
                                                          : int'(hole_count_shadow);
        for (int k = 0; k < span; k++)
        begin
            if (r.request_size > hole_sizes[k])
                continue;
            if (!found)
            begin
                found = 1'b1;
                pick  = k;
                if (r.func == FUNC_FIRST)
                    break;
            end
            // Strict comparisons keep the lowest index on a tie.
            else if (r.func == FUNC_BEST && hole_sizes[k] < hole_sizes[pick])
                pick = k;
            else if (r.func == FUNC_WORST && hole_sizes[k] > hole_sizes[pick])
                pick = k;
        end
        // When no hole fits the table is left alone and the result is all zero.
        if (!found)
            return g;
        g.granted     = 1'b1;
        g.chosen_hole = INDEX_FIELD_BITS'(pick);
        g.size_before = hole_sizes[pick];
        g.size_after  = hole_sizes[pick] - r.request_size;
        hole_sizes[pick] = g.size_after;
        return g;
    endfunction

    // Builds a random request. Most allocations are shaped to succeed: a zero request,
    // a request equal to a hole's current size (exact fits and ties), or a small one.
    // The rest are full-range values, which mostly fail and keep every bit moving.
    function automatic alloc_req_t random_request();
        alloc_req_t r;
        int         pct;
        r.hole_index   = INDEX_FIELD_BITS'($urandom_range(0, MAX_HOLES_DEF - 1));
        r.hole_size    = FIELD_BITS'($urandom);
        r.request_size = FIELD_BITS'($urandom);
        if ($urandom_range(0, 99) < 30)
        begin
            r.func = FUNC_LOAD;
            pct    = $urandom_range(0, 99);
            if (pct < 40)
                r.hole_size = FIELD_BITS'($urandom_range(0, 2000));
            else if (pct < 50)
                r.hole_size = $urandom_range(0, 1) ? '1 : '0;
        end
        else
        begin
            r.func = func_t'($urandom_range(FUNC_FIRST, FUNC_WORST));
            pct    = $urandom_range(0, 99);
            if (pct < 15)
                r.request_size = '0;
            else if (pct < 50)
                r.request_size = hole_sizes[$urandom_range(0, MAX_HOLES_DEF - 1)];
            else if (pct < 80)
                r.request_size = FIELD_BITS'($urandom_range(0, 3000));
        end
        return r;
    endfunction

    function automatic row_t req_row(func_t f, int idx, int hsize, int rsize,
                                     bit fixed_on = 1'b0, grant_t fixed_grant = '0);
        row_t row;
        row           = '0;
        row.kind      = ROW_REQ;
        row.req       = '{f, INDEX_FIELD_BITS'(idx), FIELD_BITS'(hsize), FIELD_BITS'(rsize)};
        row.has_fixed = fixed_on;
        row.fixed     = fixed_grant;
        return row;
    endfunction

    function automatic row_t cfg_row(int value);
        row_t row;
        row             = '0;
        row.kind        = ROW_CFG;
        row.count_value = COUNT_FIELD_BITS'(value);
        return row;
    endfunction

    // Presents one request from a falling edge and holds it until a rising edge
    // sees busy low. The expected result is queued at that same edge. Start stays
    // high on return, so back-to-back requests need no extra assignment to it.
    task automatic send_request(alloc_req_t r, bit fixed_on, grant_t fixed_grant);
        grant_t g;
        @(negedge clk);
        start        <= 1'b1;
        func         <= r.func;
        hole_index   <= r.hole_index;
        hole_size    <= r.hole_size;
        request_size <= r.request_size;
        do
            @(posedge clk);
        while (busy);
        g = predict_grant(r);
        expected_grants.push_back(fixed_on ? fixed_grant : g);
    endtask

    task automatic idle_for(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // The hole count is only written with nothing in flight: start is lowered, every
    // owed result must have arrived and busy must be low before the write goes out.
    task automatic write_hole_count(logic [COUNT_FIELD_BITS-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (expected_grants.size() != 0 || busy)
            @(negedge clk);
        cfg_we            <= 1'b1;
        cfg_wdata         <= value;
        hole_count_shadow  = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Results are taken at the rising edge that ends their strobe cycle and matched
    // against the oldest expectation, one field at a time.
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: result with no request pending, actual granted %0d hole %0d",
                         $time, granted, chosen_hole);
                mismatches++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (granted !== want.granted)
                begin
                    $display("%0t: granted expected %0d actual %0d",
                             $time, want.granted, granted);
                    mismatches++;
                end
                if (chosen_hole !== want.chosen_hole)
                begin
                    $display("%0t: chosen_hole expected %0d actual %0d",
                             $time, want.chosen_hole, chosen_hole);
                    mismatches++;
                end
                if (size_before !== want.size_before)
                begin
                    $display("%0t: size_before expected %0d actual %0d",
                             $time, want.size_before, size_before);
                    mismatches++;
                end
                if (size_after !== want.size_after)
                begin
                    $display("%0t: size_after expected %0d actual %0d",
                             $time, want.size_after, size_after);
                    mismatches++;
                end
            end
        end
    end

    // The watchdog restarts whenever a request is accepted or a result arrives.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int            table_fill [MAX_HOLES_DEF];
        int            phase_counts [PHASES];
        row_t          row;
        alloc_req_t    r;
        logic [COUNT_FIELD_BITS-1:0] count_value;

        // Every input is known from time zero; reset is released on a falling edge.
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FUNC_LOAD;
        hole_index   = '0;
        hole_size    = '0;
        request_size = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        mismatches   = 0;
        stall_cycles = 0;
        hole_count_shadow = HOLE_COUNT_RESET;
        foreach (hole_sizes[k])
            hole_sizes[k] = '0;

        // Hole sizes loaded by the directed part. Holes 3 and 9 share a size so that
        // best fit sees a tie, hole 0 is empty and hole 15 is the largest possible.
        table_fill   = '{0, 1200, 800, 500, 3000, 40000, 250, 12345,
                         700, 500, 5000, 60000, 1, 999, 32768, 65535};
        // Hole counts for the random part: full table, small tables, counts that
        // saturate, the empty table, one random setting, and the full table last.
        phase_counts = '{16, 3, 31, 1, 0, 17, $urandom_range(0, 31), 16};

        // With a count of zero the scan reads no hole, so this is the one allocation
        // allowed before the table is loaded; even a zero request must fail.
        directed_rows.push_back(cfg_row(0));
        directed_rows.push_back(req_row(FUNC_FIRST, 0, 0, 0, 1'b1, '{1'b0, 4'd0, 16'd0, 16'd0}));
        // Loads echo their index and value.
        foreach (table_fill[k])
            directed_rows.push_back(req_row(FUNC_LOAD, k, table_fill[k], 0, 1'b1,
                '{1'b1, 4'(k), 16'(table_fill[k]), 16'(table_fill[k])}));
        // A count above the table size saturates to the full table.
        directed_rows.push_back(cfg_row(31));
        // A zero request fits the empty hole 0.
        directed_rows.push_back(req_row(FUNC_FIRST, 7, 99, 0, 1'b1,
                                        '{1'b1, 4'd0, 16'd0, 16'd0}));
        // Only hole 15 holds the largest request; it is emptied.
        directed_rows.push_back(req_row(FUNC_BEST, 0, 0, 65535, 1'b1,
                                        '{1'b1, 4'd15, 16'd65535, 16'd0}));
        // Nothing is left that holds it, so the allocation fails.
        directed_rows.push_back(req_row(FUNC_WORST, 0, 0, 65535, 1'b1,
                                        '{1'b0, 4'd0, 16'd0, 16'd0}));
        directed_rows.push_back(req_row(FUNC_BEST, 0, 0, 500));
        directed_rows.push_back(req_row(FUNC_WORST, 15, 65535, 1));
        directed_rows.push_back(req_row(FUNC_FIRST, 0, 0, 300));
        directed_rows.push_back(cfg_row(16));
        directed_rows.push_back(req_row(FUNC_LOAD, 15, 65535, 65535, 1'b1,
                                        '{1'b1, 4'd15, 16'd65535, 16'd65535}));
        directed_rows.push_back(req_row(FUNC_WORST, 0, 0, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_hole_count(row.count_value);
            else
                send_request(row.req, row.has_fixed, row.fixed);
            if ($urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 14));
        end

        // Every hole has been loaded by now, so any count may be scanned from here on.
        for (int p = 0; p < PHASES; p++)
        begin
            count_value = COUNT_FIELD_BITS'(phase_counts[p]);
            write_hole_count(count_value);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = random_request();
                send_request(r, 1'b0, '0);
                // The final phase runs with the sender never pausing.
                if (p < PHASES - 1 && $urandom_range(0, 2) == 0)
                    idle_for($urandom_range(1, 14));
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (expected_grants.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
